// ===== sv/hbma_pkg.sv =====
// Shared types, constants and helpers of the hierarchical bitmap index allocator.
`timescale 1ns / 1ps

package hbma_pkg;

    // Tree shape: two levels of 64-bit nodes
    localparam int ENTRY_SHIFT = 6;
    localparam int FANOUT      = 1 << ENTRY_SHIFT;
    localparam int INDEX_W     = 2 * ENTRY_SHIFT;
    localparam int LEAF_WORDS  = FANOUT;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_FULL          = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [INDEX_W-1:0]  index;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0]  allocated_index;
        logic [1:0]          status;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the request beat
        logic find;    // choose leaf word, issue RAM read
        logic update;  // modify word, write back, load response
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // response register can take a new beat
    } t_sts;

    // Position of the lowest clear bit of a node word
    function automatic logic [ENTRY_SHIFT-1:0] lowest_zero(input logic [FANOUT-1:0] w);
        logic [ENTRY_SHIFT-1:0] pos;
        pos = '0;
        for (int i = FANOUT - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = ENTRY_SHIFT'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== sv/hbma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/hbma_dp.sv =====
// Datapath of the allocator: root full marks, leaf word memory, response register.
`timescale 1ns / 1ps

module hbma_dp import hbma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_in_data,
    input  logic i_out_ready,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_rsp o_out_data
);

    // Request capture
    logic                   r_op;
    logic [INDEX_W-1:0]     r_idx;

    // Root full marks (bit i set when leaf word i is all ones)
    logic [FANOUT-1:0]      r_root,    n_root;
    // Row written since reset; rows not written read as zero
    logic [LEAF_WORDS-1:0]  r_row_vld, n_row_vld;

    // Lookup results of the find step
    logic [ENTRY_SHIFT-1:0] r_addr,    n_addr;
    logic                   r_full,    n_full;
    logic                   r_rd_vld;

    // Response register
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_out_data,  n_out_data;

    // Leaf memory port
    logic [FANOUT-1:0]      rd_data;
    logic [FANOUT-1:0]      word;
    logic                   wr_en;
    logic [FANOUT-1:0]      wr_data;
    logic [ENTRY_SHIFT-1:0] leaf_pos;
    logic [FANOUT-1:0]      leaf_bit;

    hbma_ram #(
        .WIDTH (FANOUT),
        .DEPTH (LEAF_WORDS)
    ) u_leaf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.find),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_data)
    );

    // Find step: pick the leaf word from the root or from the request
    always_comb begin
        n_addr = r_addr;
        n_full = r_full;
        if (i_cmd.find) begin
            if (r_op == OP_ALLOC) begin
                n_full = &r_root;
                n_addr = lowest_zero(r_root);
            end else begin
                n_full = 1'b0;
                n_addr = r_idx[INDEX_W-1 -: ENTRY_SHIFT];
            end
        end
    end

    // Update step: set or clear the leaf bit and keep the root marks in step
    assign word = r_rd_vld ? rd_data : '0;

    always_comb begin
        n_root      = r_root;
        n_row_vld   = r_row_vld;
        wr_en       = 1'b0;
        wr_data     = word;
        leaf_pos    = '0;
        leaf_bit    = '0;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.update) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            if (r_op == OP_ALLOC) begin
                leaf_pos = lowest_zero(word);
                leaf_bit = FANOUT'(1) << leaf_pos;
                if (r_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    wr_en                      = 1'b1;
                    wr_data                    = word | leaf_bit;
                    n_row_vld[r_addr]          = 1'b1;
                    n_root[r_addr]             = &(word | leaf_bit);
                    n_out_data.allocated_index = {r_addr, leaf_pos};
                    n_out_data.status          = ST_OK;
                end
            end else begin
                leaf_pos = r_idx[ENTRY_SHIFT-1:0];
                leaf_bit = FANOUT'(1) << leaf_pos;
                if (!word[leaf_pos]) begin
                    n_out_data.status = ST_NOT_ALLOCATED;
                end else begin
                    wr_en             = 1'b1;
                    wr_data           = word & ~leaf_bit;
                    n_row_vld[r_addr] = 1'b1;
                    // word was full, so the root mark drops
                    if (&word) begin
                        n_root[r_addr] = 1'b0;
                    end
                    n_out_data.status = ST_OK;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_root      <= n_root;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_in_data.operation;
            r_idx <= i_in_data.index;
        end
        if (i_cmd.find) begin
            r_rd_vld <= r_row_vld[n_addr];
        end
        r_addr     <= n_addr;
        r_full     <= n_full;
        r_out_data <= n_out_data;
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

// ===== sv/hbma_ctrl.sv =====
// Controller state machine of the allocator: accept, find, wait for read, update.
`timescale 1ns / 1ps

module hbma_ctrl import hbma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FIND   = 4'b0010,
        S_WAIT   = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // hold until the response register can take the beat
                if (i_sts.out_free) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.latch  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.find   = (r_state == S_FIND);
    assign o_cmd.update = (r_state == S_UPDATE);

endmodule

// ===== sv/hierarchical_bitmap_id_allocator.sv =====
// Top level of the two-level bitmap index allocator (4096 indices).
//
// Usage:
//   Request channel (i_in_valid / o_in_ready, i_in_data): operation 0 allocates
//   the lowest free index, operation 1 frees the index in the beat.
//   Response channel (o_out_valid / i_out_ready, o_out_data): exactly one beat
//   per request, in order: allocated_index and status (ok, full, not allocated).
//   Timing: one request at a time; after the request beat is taken the controller
//   steps through find, wait and update, and the response becomes valid in the
//   same cycle that the controller returns to idle and can take the next request.
//   The leaf word memory takes one registered read and at most one write per request.
//   Stalls: the response register holds its beat until taken; the next request
//   can be accepted meanwhile and waits before its update step while the
//   response register is still occupied.
//   Reset (synchronous, active low): all indices free; per-row valid bits make
//   unwritten leaf words read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module hierarchical_bitmap_id_allocator import hbma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    t_cmd cmd;
    t_sts sts;

    hbma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    hbma_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Only one request in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // Failed requests (full, not allocated) return index zero
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.allocated_index == '0)
        else $error("nonzero index on failed request");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_FULL
                         || o_out_data.status == ST_NOT_ALLOCATED))
        else $error("undefined status code");

endmodule

// ===== dv/hierarchical_bitmap_id_allocator_tb.sv =====
// Self-checking testbench for the two-level bitmap index allocator.
`timescale 1ns / 1ps

module hierarchical_bitmap_id_allocator_tb;
    import hbma_pkg::*;

    localparam int    ID_SPACE   = 1 << INDEX_W;
    localparam int    FILL_IDS   = 3 * FANOUT;
    localparam int    HOLD_LONG  = 200;
    localparam int    END_SETTLE = 20;
    localparam real   RUN_LIMIT  = 5.0e6;  // ns

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    hierarchical_bitmap_id_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Allocator image: root full marks and leaf used bits
    logic [FANOUT-1:0] root_full_marks;
    logic [FANOUT-1:0] leaf_used [LEAF_WORDS];
    logic [INDEX_W-1:0] live_ids [$];

    t_rsp pending_rsps [$];
    int   mismatch_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_request;
    int   hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("hierarchical_bitmap_id_allocator verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int first_clear(input logic [FANOUT-1:0] w);
        for (int i = 0; i < FANOUT; i++) begin
            if (!w[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Expected response of one request; updates the allocator image
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   root_pos;
        int   leaf_pos;
        logic [ENTRY_SHIFT-1:0] hi;
        logic [ENTRY_SHIFT-1:0] lo;
        rsp = '0;
        if (req.operation == OP_ALLOC) begin
            root_pos = first_clear(root_full_marks);
            leaf_pos = (root_pos < 0) ? -1 : first_clear(leaf_used[root_pos]);
            if (leaf_pos < 0) begin
                rsp.status = ST_FULL;
                return rsp;
            end
            leaf_used[root_pos][leaf_pos] = 1'b1;
            if (&leaf_used[root_pos]) begin
                root_full_marks[root_pos] = 1'b1;
            end
            rsp.allocated_index = {ENTRY_SHIFT'(root_pos), ENTRY_SHIFT'(leaf_pos)};
            rsp.status          = ST_OK;
            live_ids.push_back(rsp.allocated_index);
            return rsp;
        end
        hi = req.index[INDEX_W-1:ENTRY_SHIFT];
        lo = req.index[ENTRY_SHIFT-1:0];
        if (!leaf_used[hi][lo]) begin
            rsp.status = ST_NOT_ALLOCATED;
            return rsp;
        end
        // a full leaf word loses its root mark when one bit clears
        if (&leaf_used[hi]) begin
            root_full_marks[hi] = 1'b0;
        end
        leaf_used[hi][lo] = 1'b0;
        for (int i = 0; i < live_ids.size(); i++) begin
            if (live_ids[i] == req.index) begin
                live_ids.delete(i);
                break;
            end
        end
        rsp.status = ST_OK;
        return rsp;
    endfunction

    // Sends one request beat; entered and left at a falling edge
    task automatic send_req(input logic op, input logic [INDEX_W-1:0] idx);
        t_req req;
        req.operation = op;
        req.index     = idx;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rsps.push_back(apply_request(req));
        @(negedge i_clk);
    endtask

    // Sender pause until every outstanding response has been taken
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [INDEX_W-1:0] pick_live_id();
        return live_ids[$urandom_range(live_ids.size() - 1)];
    endfunction

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch($sformatf("unexpected response idx=%0d st=%0d",
                    o_out_data.allocated_index, o_out_data.status));
            end else begin
                want = pending_rsps.pop_front();
                if (o_out_data.allocated_index !== want.allocated_index) begin
                    report_mismatch($sformatf("allocated_index got %0d want %0d",
                        o_out_data.allocated_index, want.allocated_index));
                end
                if (o_out_data.status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                        o_out_data.status, want.status));
                end
            end
        end
    end

    // Reuse of the lowest index, double free, free of never-granted ids
    task automatic test_basic();
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);           // index field ignored on allocate
        send_req(OP_FREE, 12'd0);
        send_req(OP_FREE, 12'd0);         // already free
        send_req(OP_ALLOC, 12'd2730);
        send_req(OP_FREE, 12'd4095);      // never granted
        send_req(OP_FREE, 12'd2730);      // never granted
        send_req(OP_FREE, 12'd1);
        send_req(OP_FREE, 12'd0);
        send_req(OP_FREE, 12'd1);
        wait_drain();
    endtask

    // Fill the lowest leaf words so their root marks set, then punch holes
    task automatic test_fill_and_full();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < FILL_IDS; i++) begin
            send_req(OP_ALLOC, INDEX_W'($urandom_range(ID_SPACE - 1)));
        end
        send_req(OP_FREE, 12'd4095);      // never granted
        send_req(OP_FREE, 12'd0);         // full word loses its root mark
        send_req(OP_FREE, 12'd64);
        send_req(OP_FREE, 12'd65);
        send_req(OP_FREE, 12'd0);         // freed just above
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '1);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);
        send_req(OP_ALLOC, '0);           // past the filled words
        wait_drain();
    endtask

    // Long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_LONG;
        for (int i = 0; i < 20; i++) begin
            if (i % 2 == 0 && live_ids.size() != 0) begin
                send_req(OP_FREE, pick_live_id());
            end else begin
                send_req(OP_ALLOC, INDEX_W'($urandom));
            end
        end
        wait_drain();
    endtask

    // Mostly allocates and frees of live ids, some frees of random ids
    task automatic test_random(input int count, input int snd_pct, input int rcv_pct,
                               input int alloc_pct);
        int roll;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < alloc_pct) begin
                send_req(OP_ALLOC, INDEX_W'($urandom));
            end else if (roll < 88 && live_ids.size() != 0) begin
                send_req(OP_FREE, pick_live_id());
            end else begin
                send_req(OP_FREE, INDEX_W'($urandom_range(ID_SPACE - 1)));
            end
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_out_ready     = 1'b0;
        mismatch_count  = 0;
        hold_request    = 0;
        hold_left       = 0;
        send_idle_pct   = 22;
        recv_idle_pct   = 54;
        root_full_marks = '0;
        foreach (leaf_used[i]) begin
            leaf_used[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic();
        test_fill_and_full();
        test_backpressure();
        // start from the filled words, then drift toward sparse
        test_random(72, 22, 54, 50);
        test_random(72, 54, 22, 45);
        test_random(72, 0, 0, 30);

        i_in_valid <= 1'b0;
        repeat (END_SETTLE) @(negedge i_clk);
        if (pending_rsps.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived",
                pending_rsps.size()));
        end
        if (mismatch_count == 0) begin
            $display("hierarchical_bitmap_id_allocator verification clean");
        end else begin
            $display("hierarchical_bitmap_id_allocator verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/hbma_pkg.sv
sv/hbma_ram.sv
sv/hbma_dp.sv
sv/hbma_ctrl.sv
sv/hierarchical_bitmap_id_allocator.sv
dv/hierarchical_bitmap_id_allocator_tb.sv
